@@ sv/csps_pkg.sv @@
// Package for the circular successor position search block.
// Holds the operation codes, the channel word types and the default sizes.
// No dependencies.
package csps_pkg;

  localparam int DEPTH = 512;
  localparam int KEY_BITS = 16;

  localparam int OP_W = 2;
  localparam int KEY_W = 16;
  localparam int POSITION_W = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SUCC   = 2'd2,
    OP_MIN    = 2'd3
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic                  table_empty;
    logic                  wrapped;
  } out_word_t;

endpackage

@@ sv/circular_successor_position_search.sv @@
// Top level of the circular successor position search block.
// Depends on csps_pkg and csps_cell.
//
// Usage: words enter on in_valid/in_ready/in_word and results leave on
// out_valid/out_ready/out_word, both with a valid/ready handshake.
// A clear word empties the table and an append word stores its key at the
// next position; an append to a full table is dropped. Neither gives a result.
// A successor or minimum query gives exactly one result word.
// Each table entry lives in one cell of a chain of DEPTH cells. A query
// travels down the chain one cell per cycle unless stalled, and its result is
// registered at the output after the last cell. The chain is fully pipelined:
// one word of any kind is accepted every cycle unless stalled, and results
// leave in order. When the receiver stalls with a result pending, the whole
// chain holds and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the table and drops all queries in flight; the stored keys
// are not cleared, since no entry is read before it is written again.
module circular_successor_position_search #(
  parameter int DEPTH = csps_pkg::DEPTH,
  parameter int KEY_BITS = csps_pkg::KEY_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csps_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output csps_pkg::out_word_t out_word
);

  localparam int POS_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic                advance;
  logic                accept;
  logic [CNT_BITS-1:0] count;
  logic [KEY_BITS-1:0] in_key;
  logic                wr_en;

  logic                c_valid   [DEPTH+1];
  logic                c_min_op  [DEPTH+1];
  logic [KEY_BITS-1:0] c_q       [DEPTH+1];
  logic [CNT_BITS-1:0] c_count   [DEPTH+1];
  logic                c_s_found [DEPTH+1];
  logic [KEY_BITS-1:0] c_s_key   [DEPTH+1];
  logic [POS_BITS-1:0] c_s_pos   [DEPTH+1];
  logic                c_m_found [DEPTH+1];
  logic [KEY_BITS-1:0] c_m_key   [DEPTH+1];
  logic [POS_BITS-1:0] c_m_pos   [DEPTH+1];

  csps_pkg::out_word_t result;
  logic [POS_BITS-1:0] sel_pos;

  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign accept = in_valid && in_ready;
  assign in_key = KEY_BITS'(in_word.key);
  assign wr_en = accept && (in_word.operation == csps_pkg::OP_APPEND) && (count < FULL_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && in_word.operation == csps_pkg::OP_CLEAR) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  assign c_valid[0]   = accept && (in_word.operation == csps_pkg::OP_SUCC ||
                                   in_word.operation == csps_pkg::OP_MIN);
  assign c_min_op[0]  = in_word.operation == csps_pkg::OP_MIN;
  assign c_q[0]       = in_key;
  assign c_count[0]   = count;
  assign c_s_found[0] = 1'b0;
  assign c_s_key[0]   = '0;
  assign c_s_pos[0]   = '0;
  assign c_m_found[0] = 1'b0;
  assign c_m_key[0]   = '0;
  assign c_m_pos[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    csps_cell #(
      .KEY_BITS(KEY_BITS),
      .POS_BITS(POS_BITS),
      .CNT_BITS(CNT_BITS),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .advance(advance),
      .wr_en(wr_en),
      .wr_idx(count[POS_BITS-1:0]),
      .wr_key(in_key),
      .i_valid(c_valid[i]),
      .i_min_op(c_min_op[i]),
      .i_q(c_q[i]),
      .i_count(c_count[i]),
      .i_s_found(c_s_found[i]),
      .i_s_key(c_s_key[i]),
      .i_s_pos(c_s_pos[i]),
      .i_m_found(c_m_found[i]),
      .i_m_key(c_m_key[i]),
      .i_m_pos(c_m_pos[i]),
      .o_valid(c_valid[i+1]),
      .o_min_op(c_min_op[i+1]),
      .o_q(c_q[i+1]),
      .o_count(c_count[i+1]),
      .o_s_found(c_s_found[i+1]),
      .o_s_key(c_s_key[i+1]),
      .o_s_pos(c_s_pos[i+1]),
      .o_m_found(c_m_found[i+1]),
      .o_m_key(c_m_key[i+1]),
      .o_m_pos(c_m_pos[i+1])
    );
  end

  always_comb begin
    result.table_empty = c_count[DEPTH] == '0;
    result.wrapped = 1'b0;
    sel_pos = c_m_pos[DEPTH];
    if (result.table_empty) begin
      sel_pos = '0;
    end else if (!c_min_op[DEPTH]) begin
      if (c_s_found[DEPTH]) begin
        sel_pos = c_s_pos[DEPTH];
      end else begin
        result.wrapped = 1'b1;
      end
    end
    result.position = csps_pkg::POSITION_W'(sel_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_valid[DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count beyond table depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + 1'b1)
    else $error("append did not advance the entry count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.table_empty |-> out_word.position == '0 && !out_word.wrapped)
    else $error("empty-table result carries a position or wrap flag");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the chain is stalled");
`endif

endmodule

@@ sv/csps_cell.sv @@
// One cell of the search chain: stores one table entry and refines the
// running successor and minimum of the query word passing through it.
// Depends on nothing but its parameters.
module csps_cell #(
  parameter int KEY_BITS = 16,
  parameter int POS_BITS = 9,
  parameter int CNT_BITS = 10,
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                wr_en,
  input  logic [POS_BITS-1:0] wr_idx,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic                i_valid,
  input  logic                i_min_op,
  input  logic [KEY_BITS-1:0] i_q,
  input  logic [CNT_BITS-1:0] i_count,
  input  logic                i_s_found,
  input  logic [KEY_BITS-1:0] i_s_key,
  input  logic [POS_BITS-1:0] i_s_pos,
  input  logic                i_m_found,
  input  logic [KEY_BITS-1:0] i_m_key,
  input  logic [POS_BITS-1:0] i_m_pos,
  output logic                o_valid,
  output logic                o_min_op,
  output logic [KEY_BITS-1:0] o_q,
  output logic [CNT_BITS-1:0] o_count,
  output logic                o_s_found,
  output logic [KEY_BITS-1:0] o_s_key,
  output logic [POS_BITS-1:0] o_s_pos,
  output logic                o_m_found,
  output logic [KEY_BITS-1:0] o_m_key,
  output logic [POS_BITS-1:0] o_m_pos
);

  localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(INDEX);
  localparam logic [CNT_BITS-1:0] MY_CNT = CNT_BITS'(INDEX);

  logic [KEY_BITS-1:0] entry;
  logic                in_use;
  logic                take_s;
  logic                take_m;

  assign in_use = MY_CNT < i_count;
  assign take_s = in_use && (entry > i_q) && (!i_s_found || entry < i_s_key);
  assign take_m = in_use && (!i_m_found || entry < i_m_key);

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY_POS) begin
      entry <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_min_op  <= i_min_op;
      o_q       <= i_q;
      o_count   <= i_count;
      o_s_found <= i_s_found || take_s;
      o_s_key   <= take_s ? entry : i_s_key;
      o_s_pos   <= take_s ? MY_POS : i_s_pos;
      o_m_found <= i_m_found || take_m;
      o_m_key   <= take_m ? entry : i_m_key;
      o_m_pos   <= take_m ? MY_POS : i_m_pos;
    end
  end

endmodule
